// ===== design/btlc_pkg.sv =====
// Shared types, constants and a helper function of the bitmap text to LCD command unit.
package btlc_pkg;

    localparam int GLYPH_COUNT    = 96;
    localparam int MAX_GLYPH_ROWS = 32;
    localparam int STORE_DEPTH    = GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);

    // Shared adder width: a 10-bit cursor plus a glyph size and a carry.
    localparam int ALU_W = 11;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DRAW  = 2'd2;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_PARAM = 2'd1;
    localparam logic [1:0] KIND_ROW   = 2'd2;

    localparam logic [7:0] LCD_COL_ADDR  = 8'h2A;
    localparam logic [7:0] LCD_PAGE_ADDR = 8'h2B;
    localparam logic [7:0] LCD_MEM_WRITE = 8'h2C;

    localparam logic [7:0] SPACE_CODE     = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE = 8'd126;

    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GLYPH_WIDTH   = 2'd2;
    localparam logic [1:0] CFG_GLYPH_HEIGHT  = 2'd3;

    localparam logic [8:0] RST_SCREEN_WIDTH  = 9'd240;
    localparam logic [8:0] RST_SCREEN_HEIGHT = 9'd320 - 9'd0;
    localparam logic [4:0] RST_GLYPH_WIDTH   = 5'd7;
    localparam logic [5:0] RST_GLYPH_HEIGHT  = 6'd10;

    localparam logic [4:0] MAX_GLYPH_WIDTH = 5'd16;

    typedef struct packed {
        logic [8:0] screen_width;
        logic [8:0] screen_height;
        logic [4:0] glyph_width;
        logic [5:0] glyph_height;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [15:0]      value;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             dec;
        logic [ALU_W-1:0] limit;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             ge;
    } alu_resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_STEPY,
        ST_CHKY,
        ST_CALCX,
        ST_CALCY,
        ST_CMD,
        ST_ROW
    } state_t;

    // Order of the command and parameter bytes ahead of the glyph rows.
    typedef enum logic [3:0] {
        SLOT_COL_CMD,
        SLOT_X0_HI,
        SLOT_X0_LO,
        SLOT_X1_HI,
        SLOT_X1_LO,
        SLOT_PAGE_CMD,
        SLOT_Y0_HI,
        SLOT_Y0_LO,
        SLOT_Y1_HI,
        SLOT_Y1_LO,
        SLOT_MEM_CMD
    } slot_t;

    function automatic logic glyph_ok(input logic [7:0] code);
        logic [7:0] glyph;
        begin
            glyph = code - SPACE_CODE;
            return (code >= SPACE_CODE) && (code <= LAST_PRINTABLE) &&
                   (glyph < 8'(GLYPH_COUNT));
        end
    endfunction

endpackage

// ===== design/btlc_alu.sv =====
// Shared adder and comparator used by the sequencer for all cursor arithmetic.
module btlc_alu
    import btlc_pkg::*;
(
    input  alu_req_t  req,
    output alu_resp_t resp
);

    // A decrement folds in as an all-ones third operand.
    assign resp.sum = req.a + req.b + {ALU_W{req.dec}};
    assign resp.ge  = (resp.sum >= req.limit);

endmodule

// ===== design/btlc_glyph_mem.sv =====
// Single-port glyph row store with registered read data.
module btlc_glyph_mem
    import btlc_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [15:0]       wdata,
    output logic [15:0]       rdata
);

    logic [15:0] mem [STORE_DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/btlc_seq.sv =====
// Sequencer: cursor state, wrap and stop decisions, and result generation.
module btlc_seq
    import btlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [8:0]  pos_x,
    input  logic [8:0]  pos_y,
    input  logic [7:0]  char_code,
    input  logic [4:0]  row_index,
    input  logic [15:0] row_bits,
    input  logic        slot_free,
    output result_t     emit
);

    state_t      state_reg, state_next;
    slot_t       slot_reg, slot_next;
    logic [8:0]  x_reg, x_next;
    logic [9:0]  y_reg, y_next;
    logic        stopped_reg, stopped_next;
    logic [7:0]  code_reg, code_next;
    logic [9:0]  x1_reg, x1_next;
    logic [10:0] y1_reg, y1_next;
    logic [4:0]  row_cnt_reg, row_cnt_next;

    alu_req_t          alu_req;
    alu_resp_t         alu_resp;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [15:0]       mem_rdata;
    logic              row_last;
    logic              load_ok;
    logic              draw_ok;
    logic [15:0]       row_mask;

    function automatic logic [ADDR_W-1:0] glyph_addr(input logic [7:0] code,
                                                     input logic [4:0] row);
        logic [7:0] glyph;
        begin
            glyph = code - SPACE_CODE;
            return ADDR_W'(glyph) * ADDR_W'(MAX_GLYPH_ROWS) + ADDR_W'(row);
        end
    endfunction

    btlc_alu u_alu (
        .req  (alu_req),
        .resp (alu_resp)
    );

    btlc_glyph_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (row_bits),
        .rdata (mem_rdata)
    );

    assign load_ok  = (command == CMD_LOAD) && glyph_ok(char_code) &&
                      ({1'b0, row_index} < 6'(MAX_GLYPH_ROWS));
    assign draw_ok  = (command == CMD_DRAW) && !stopped_reg && glyph_ok(char_code);
    assign row_last = (({1'b0, row_cnt_reg} + 6'd1) == cfg.glyph_height);
    assign row_mask = 16'hFFFF << (5'd16 - cfg.glyph_width);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && draw_ok)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:  state_next = alu_resp.ge ? ST_STEPY : ST_CALCX;
            ST_STEPY: state_next = ST_CHKY;
            ST_CHKY:
            begin
                if (alu_resp.ge || (code_reg == SPACE_CODE))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CALCX;
                end
            end
            ST_CALCX: state_next = ST_CALCY;
            ST_CALCY: state_next = ST_CMD;
            ST_CMD:
            begin
                if (slot_free && (slot_reg == SLOT_MEM_CMD))
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (slot_free && row_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, adder operands, memory control and results.
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        alu_req.a     = {2'b00, x_reg};
        alu_req.b     = {6'd0, cfg.glyph_width};
        alu_req.dec   = 1'b0;
        alu_req.limit = {2'b00, cfg.screen_width};
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = glyph_addr(code_reg, row_cnt_reg + 5'd1);
        emit.valid    = 1'b0;
        emit.kind     = KIND_CMD;
        emit.value    = 16'd0;
        emit.last     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                mem_we   = in_valid && load_ok;
                mem_addr = glyph_addr(char_code, row_index);
            end
            ST_WRAP:
            begin
                alu_req.limit = {2'b00, cfg.screen_width};
            end
            ST_STEPY, ST_CHKY:
            begin
                alu_req.a     = {1'b0, y_reg};
                alu_req.b     = {5'd0, cfg.glyph_height};
                alu_req.limit = {2'b00, cfg.screen_height};
            end
            ST_CALCX:
            begin
                alu_req.dec = 1'b1;
            end
            ST_CALCY:
            begin
                alu_req.a   = {1'b0, y_reg};
                alu_req.b   = {5'd0, cfg.glyph_height};
                alu_req.dec = 1'b1;
                mem_re      = 1'b1;
                mem_addr    = glyph_addr(code_reg, 5'd0);
            end
            ST_CMD:
            begin
                emit.valid = slot_free;
                emit.kind  = KIND_PARAM;
                case (slot_reg)
                    SLOT_COL_CMD:
                    begin
                        emit.kind  = KIND_CMD;
                        emit.value = {8'd0, LCD_COL_ADDR};
                    end
                    SLOT_X0_HI:    emit.value = {15'd0, x_reg[8]};
                    SLOT_X0_LO:    emit.value = {8'd0, x_reg[7:0]};
                    SLOT_X1_HI:    emit.value = {14'd0, x1_reg[9:8]};
                    SLOT_X1_LO:    emit.value = {8'd0, x1_reg[7:0]};
                    SLOT_PAGE_CMD:
                    begin
                        emit.kind  = KIND_CMD;
                        emit.value = {8'd0, LCD_PAGE_ADDR};
                    end
                    SLOT_Y0_HI:    emit.value = {14'd0, y_reg[9:8]};
                    SLOT_Y0_LO:    emit.value = {8'd0, y_reg[7:0]};
                    SLOT_Y1_HI:    emit.value = {13'd0, y1_reg[10:8]};
                    SLOT_Y1_LO:    emit.value = {8'd0, y1_reg[7:0]};
                    SLOT_MEM_CMD:
                    begin
                        emit.kind  = KIND_CMD;
                        emit.value = {8'd0, LCD_MEM_WRITE};
                    end
                    default:       emit.value = 16'd0;
                endcase
            end
            ST_ROW:
            begin
                // The read of the following row is issued as this one leaves.
                mem_re     = slot_free;
                emit.valid = slot_free;
                emit.kind  = KIND_ROW;
                emit.value = mem_rdata & row_mask;
                emit.last  = row_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        slot_next    = slot_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        stopped_next = stopped_reg;
        code_next    = code_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        row_cnt_next = row_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    code_next = char_code;
                    if (command == CMD_START)
                    begin
                        x_next       = pos_x;
                        y_next       = {1'b0, pos_y};
                        stopped_next = 1'b0;
                    end
                end
            end
            ST_WRAP:
            begin
                if (alu_resp.ge)
                begin
                    x_next = 9'd0;
                end
            end
            ST_STEPY: y_next = alu_resp.sum[9:0];
            ST_CHKY:
            begin
                if (alu_resp.ge)
                begin
                    stopped_next = 1'b1;
                end
            end
            ST_CALCX: x1_next = alu_resp.sum[9:0];
            ST_CALCY:
            begin
                y1_next      = alu_resp.sum;
                slot_next    = SLOT_COL_CMD;
                row_cnt_next = 5'd0;
            end
            ST_CMD:
            begin
                if (slot_free && (slot_reg != SLOT_MEM_CMD))
                begin
                    slot_next = slot_t'(slot_reg + 4'd1);
                end
            end
            ST_ROW:
            begin
                if (slot_free)
                begin
                    row_cnt_next = row_cnt_reg + 5'd1;
                    if (row_last)
                    begin
                        x_next = alu_resp.sum[8:0];
                    end
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= SLOT_COL_CMD;
            x_reg       <= 9'd0;
            y_reg       <= 10'd0;
            stopped_reg <= 1'b0;
            row_cnt_reg <= 5'd0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            stopped_reg <= stopped_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
    end

endmodule

// ===== design/bitmap_text_to_lcd_commands_unit.sv =====
// Top level of the bitmap text to LCD command unit: config registers and output register.

// The unit turns a text stream into LCD controller traffic. A load item
// (command 0) stores one 16-bit glyph row, a start item (command 1) places
// the text cursor and clears the stopped flag. A draw item (command 2) runs
// the wrap check, a line step and bottom check after a wrap, the window end
// sums, the command and parameter bytes and the glyph rows; a character that
// is ignored, stopped or swallowed as a leading space after a wrap finishes
// sooner and produces no transfer. The sequencer runs all cursor arithmetic
// through one shared adder and sends one result per cycle while the output
// register is free: eleven command and parameter bytes, then one glyph row
// per cycle read from the single-port glyph store. A drawn character ends
// with a row transfer that has last set. The output register decouples the
// two sides, so a finished result may wait while the unit already works on
// the rest. Configuration writes are accepted at any time but are meant
// only for an idle unit; values outside range are saturated. The glyph
// store has no reset and must be loaded before a glyph is drawn.
module bitmap_text_to_lcd_commands_unit
    import btlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [8:0]  pos_x,
    input  logic [8:0]  pos_y,
    input  logic [7:0]  char_code,
    input  logic [4:0]  row_index,
    input  logic [15:0] row_bits,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] value,
    output logic        last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    cfg_t        cfg;
    result_t     emit;
    logic        slot_free;

    logic [8:0]  screen_width_reg, screen_width_next;
    logic [8:0]  screen_height_reg, screen_height_next;
    logic [4:0]  glyph_width_reg, glyph_width_next;
    logic [5:0]  glyph_height_reg, glyph_height_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg;
    logic [15:0] value_reg;
    logic        last_reg;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    // A write saturates its value into the legal range of the register.
    always_comb
    begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        glyph_width_next   = glyph_width_reg;
        glyph_height_next  = glyph_height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:
                begin
                    screen_width_next = (cfg_data == 9'd0) ? 9'd1 : cfg_data;
                end
                CFG_SCREEN_HEIGHT:
                begin
                    screen_height_next = (cfg_data == 9'd0) ? 9'd1 : cfg_data;
                end
                CFG_GLYPH_WIDTH:
                begin
                    if (cfg_data[4:0] == 5'd0)
                    begin
                        glyph_width_next = 5'd1;
                    end
                    else if (cfg_data[4:0] > MAX_GLYPH_WIDTH)
                    begin
                        glyph_width_next = MAX_GLYPH_WIDTH;
                    end
                    else
                    begin
                        glyph_width_next = cfg_data[4:0];
                    end
                end
                CFG_GLYPH_HEIGHT:
                begin
                    if (cfg_data[5:0] == 6'd0)
                    begin
                        glyph_height_next = 6'd1;
                    end
                    else if (cfg_data[5:0] > 6'(MAX_GLYPH_ROWS))
                    begin
                        glyph_height_next = 6'(MAX_GLYPH_ROWS);
                    end
                    else
                    begin
                        glyph_height_next = cfg_data[5:0];
                    end
                end
                default:
                begin
                    screen_width_next = screen_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            glyph_width_reg   <= RST_GLYPH_WIDTH;
            glyph_height_reg  <= RST_GLYPH_HEIGHT;
        end
        else
        begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            glyph_width_reg   <= glyph_width_next;
            glyph_height_reg  <= glyph_height_next;
        end
    end

    assign cfg.screen_width  = screen_width_reg;
    assign cfg.screen_height = screen_height_reg;
    assign cfg.glyph_width   = glyph_width_reg;
    assign cfg.glyph_height  = glyph_height_reg;

    // The sequencer may hand over a result whenever the output register is
    // empty or is being emptied by a transfer in this same cycle.
    assign slot_free = !out_valid_reg || out_ready;

    btlc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .char_code (char_code),
        .row_index (row_index),
        .row_bits  (row_bits),
        .slot_free (slot_free),
        .emit      (emit)
    );

    // Output register.
    always_comb
    begin
        if (emit.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            kind_reg  <= emit.kind;
            value_reg <= emit.value;
            last_reg  <= emit.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // A new result must never overwrite one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> (!out_valid_reg || out_ready))
        else $error("result handed over while output register is occupied");

    // Only a glyph row can close a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (kind == KIND_ROW))
        else $error("last flag on a command or parameter byte");

    // Glyph sizes always stay within their saturated ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        (glyph_width_reg != 5'd0) && (glyph_width_reg <= MAX_GLYPH_WIDTH) &&
        (glyph_height_reg != 6'd0) && (glyph_height_reg <= 6'(MAX_GLYPH_ROWS)))
        else $error("glyph size register out of range");
`endif

endmodule

// ===== tb/bitmap_text_to_lcd_commands_unit_test.sv =====
// Self-checking testbench for the bitmap text to LCD command unit, with randomized traffic.
module bitmap_text_to_lcd_commands_unit_test;
    import btlc_pkg::*;

    // Command 3 has no meaning; the unit must drop it without a trace.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Upper bound on the run. It lies well above what a correct run needs even
    // with the heaviest stalls, so this only trips on a hang.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles to wait after the last expected transfer. A swallowed space or a
    // stopped character may still be in flight with nothing to show for it.
    localparam int SETTLE_CYCLES = 64;

    // One transfer on the result channel.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        last;
    } lcd_beat_t;

    // Tracks the unit's cursor, configuration and glyph store, turns every
    // accepted item into the LCD traffic it must cause, and checks the
    // result channel against that traffic in order.
    class lcd_traffic_board;
        int unsigned scr_w;
        int unsigned scr_h;
        int unsigned cell_w;
        int unsigned cell_h;
        int unsigned col;
        int unsigned line;
        bit          halted;
        logic [15:0] font_rows [GLYPH_COUNT * MAX_GLYPH_ROWS];
        bit [31:0]   rows_loaded [GLYPH_COUNT];
        lcd_beat_t   traffic_due [$];
        int unsigned fault_count;

        // Registers and cursor start from their reset values.
        function new();
            scr_w = RST_SCREEN_WIDTH;
            scr_h = RST_SCREEN_HEIGHT;
            cell_w = RST_GLYPH_WIDTH;
            cell_h = RST_GLYPH_HEIGHT;
            col = 0;
            line = 0;
            halted = 0;
            fault_count = 0;
            foreach (rows_loaded[g])
                rows_loaded[g] = '0;
        endfunction

        static function bit printable(logic [7:0] code);
            return code >= SPACE_CODE && code <= LAST_PRINTABLE &&
                   int'(code - SPACE_CODE) < GLYPH_COUNT;
        endfunction

        // True when every row that a draw at the current height sends has been
        // loaded, so a draw never sends data from an unwritten store entry.
        function bit glyph_ready(logic [7:0] code);
            logic [32:0] need;
            need = (33'd1 << cell_h) - 33'd1;
            return (rows_loaded[code - SPACE_CODE] & need[31:0]) == need[31:0];
        endfunction

        // Out-of-range writes saturate; only the low bits of each field count.
        function void apply_register(logic [1:0] idx, logic [8:0] data);
            case (idx)
                CFG_SCREEN_WIDTH:  scr_w = (data == 0) ? 1 : data;
                CFG_SCREEN_HEIGHT: scr_h = (data == 0) ? 1 : data;
                CFG_GLYPH_WIDTH:   cell_w = (data[4:0] == 0) ? 1 :
                                            (data[4:0] > 16) ? 16 : data[4:0];
                CFG_GLYPH_HEIGHT:  cell_h = (data[5:0] == 0) ? 1 :
                                            (data[5:0] > MAX_GLYPH_ROWS) ?
                                            MAX_GLYPH_ROWS : data[5:0];
                default: ;
            endcase
        endfunction

        function void queue_beat(logic [1:0] k, logic [15:0] v, logic l);
            lcd_beat_t b;
            b.kind = k;
            b.value = v;
            b.last = l;
            traffic_due.push_back(b);
        endfunction

        // A window coordinate goes out as two parameter bytes, high first.
        function void queue_word(int unsigned v);
            queue_beat(KIND_PARAM, 16'((v >> 8) & 8'hFF), 1'b0);
            queue_beat(KIND_PARAM, 16'(v & 8'hFF), 1'b0);
        endfunction

        function void render_glyph(logic [7:0] code);
            logic [15:0] keep;
            int unsigned base;
            // Wrap to the next text line when the cell would reach the right
            // edge; stop for good when that line would reach the bottom, and
            // swallow a space that lands at the start of the new line.
            if (col + cell_w >= scr_w)
            begin
                col = 0;
                line = (line + cell_h) & 10'h3FF;
                if (line + cell_h >= scr_h)
                begin
                    halted = 1;
                    return;
                end
                if (code == SPACE_CODE)
                    return;
            end
            queue_beat(KIND_CMD, 16'(LCD_COL_ADDR), 1'b0);
            queue_word(col);
            queue_word(col + cell_w - 1);
            queue_beat(KIND_CMD, 16'(LCD_PAGE_ADDR), 1'b0);
            queue_word(line);
            queue_word(line + cell_h - 1);
            queue_beat(KIND_CMD, 16'(LCD_MEM_WRITE), 1'b0);
            keep = 16'hFFFF << (16 - cell_w);
            base = int'(code - SPACE_CODE) * MAX_GLYPH_ROWS;
            for (int r = 0; r < cell_h; r++)
                queue_beat(KIND_ROW, font_rows[base + r] & keep, r == cell_h - 1);
            col = (col + cell_w) & 9'h1FF;
        endfunction

        function void note_item(logic [1:0] cmd, logic [8:0] x, logic [8:0] y,
                                logic [7:0] code, logic [4:0] row, logic [15:0] bits);
            case (cmd)
                CMD_LOAD:
                    if (printable(code))
                    begin
                        font_rows[int'(code - SPACE_CODE) * MAX_GLYPH_ROWS + row] = bits;
                        rows_loaded[code - SPACE_CODE][row] = 1'b1;
                    end
                CMD_START:
                begin
                    col = x;
                    line = y;
                    halted = 0;
                end
                CMD_DRAW:
                    if (!halted && printable(code))
                        render_glyph(code);
                default: ;
            endcase
        endfunction

        function void check_beat(logic [1:0] got_kind, logic [15:0] got_value,
                                 logic got_last);
            lcd_beat_t want;
            if (traffic_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected transfer: kind %0d value %h last %0d",
                             got_kind, got_value, got_last);
                return;
            end
            want = traffic_due.pop_front();
            if (got_kind !== want.kind || got_value !== want.value || got_last !== want.last)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("transfer mismatch: expected kind %0d value %h last %0d, %s %0d %h %0d",
                             want.kind, want.value, want.last, "got",
                             got_kind, got_value, got_last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_LOAD;
    logic [8:0]  pos_x = '0;
    logic [8:0]  pos_y = '0;
    logic [7:0]  char_code = '0;
    logic [4:0]  row_index = '0;
    logic [15:0] row_bits = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SCREEN_WIDTH;
    logic [8:0]  cfg_data = '0;

    lcd_traffic_board board;

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    // Items of the current phase that have been transferred to the unit.
    int phase_items = 0;
    int cycle_count = 0;

    // Character codes that text runs of the current phase draw from.
    logic [7:0] phase_codes [3];

    bitmap_text_to_lcd_commands_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .char_code (char_code),
        .row_index (row_index),
        .row_bits  (row_bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .value     (value),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hang ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side. Each transfer is checked against the oldest expectation,
    // sampled with the values that were present just before the edge. The
    // ready line is redrawn every cycle so stalls land anywhere in a glyph.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                board.check_beat(kind, value, last);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // All driving tasks start and end just after a rising edge, so each
    // signal gets at most one nonblocking update per edge.
    task automatic send_item(input logic [1:0] cmd, input logic [8:0] x, input logic [8:0] y,
                             input logic [7:0] code, input logic [4:0] row,
                             input logic [15:0] bits);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        pos_x <= x;
        pos_y <= y;
        char_code <= code;
        row_index <= row;
        row_bits <= bits;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        board.note_item(cmd, x, y, code, row, bits);
        phase_items++;
    endtask

    task automatic load_row(input logic [7:0] code, input logic [4:0] row,
                            input logic [15:0] bits);
        send_item(CMD_LOAD, 9'($urandom_range(511)), 9'($urandom_range(511)), code, row, bits);
    endtask

    task automatic place_cursor(input logic [8:0] x, input logic [8:0] y);
        send_item(CMD_START, x, y, 8'($urandom_range(255)), 5'($urandom_range(31)),
                  16'($urandom_range(16'hFFFF)));
    endtask

    // A printable glyph that is not fully loaded for the current height gets
    // its rows loaded first, so the unit never sends data from an unwritten store entry.
    task automatic draw_char(input logic [7:0] code);
        int unsigned r;
        if (lcd_traffic_board::printable(code) && !board.glyph_ready(code))
        begin
            for (r = 0; r < board.cell_h; r++)
            begin
                load_row(code, 5'(r), 16'($urandom_range(16'hFFFF)));
            end
        end
        send_item(CMD_DRAW, 9'($urandom_range(511)), 9'($urandom_range(511)), code,
                  5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)));
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.apply_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender back until every expected transfer has arrived, then
    // give the unit time to finish any item that produces nothing.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.traffic_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register settings of the random phases, the extremes among them.
    task automatic configure_phase(input int phase);
        logic [8:0] w, h, gw, gh;
        case (phase)
            0:
            begin
                w = 9'd240; h = 9'd300; gw = 9'd7; gh = 9'd10;
            end
            1:
            begin
                // Widest and tallest: glyph fields saturate to 16 and 32.
                w = 9'h1FF; h = 9'h1FF; gw = 9'h1FF; gh = 9'h1FF;
            end
            2:
            begin
                // All zero saturates to one; every character then stops.
                w = 9'd0; h = 9'd0; gw = 9'd0; gh = 9'd0;
            end
            4:
            begin
                // Upper data bits above each field must be ignored.
                w = 9'd64; h = 9'd48; gw = 9'h108; gh = 9'h045;
            end
            3:
            begin
                w = 9'($urandom_range(511)); h = 9'($urandom_range(511));
                gw = 9'($urandom_range(511)); gh = 9'($urandom_range(511));
            end
            default:
            begin
                w = 9'($urandom_range(511)); h = 9'($urandom_range(511));
                gw = 9'($urandom_range(511)); gh = 9'($urandom_range(1, 12));
            end
        endcase
        write_register(CFG_SCREEN_WIDTH, w);
        write_register(CFG_SCREEN_HEIGHT, h);
        write_register(CFG_GLYPH_WIDTH, gw);
        write_register(CFG_GLYPH_HEIGHT, gh);
    endtask

    // Mostly text runs (a start followed by characters from a small set with
    // many spaces), mixed with stray loads, unused commands, random codes and
    // the odd full drain of the result side.
    task automatic run_phase(input int budget);
        int pick;
        logic [8:0] x, y;
        phase_codes[0] = SPACE_CODE;
        phase_codes[1] = 8'($urandom_range(33, 126));
        phase_codes[2] = 8'($urandom_range(33, 126));
        phase_items = 0;
        while (phase_items < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                x = ($urandom_range(4) == 0) ? 9'($urandom_range(511)) :
                                               9'($urandom_range(board.scr_w - 1));
                y = ($urandom_range(4) == 0) ? 9'($urandom_range(511)) :
                                               9'($urandom_range(board.scr_h - 1));
                place_cursor(x, y);
                repeat ($urandom_range(1, 8))
                begin
                    if (phase_items < budget)
                    begin
                        draw_char(($urandom_range(2) == 0) ? SPACE_CODE :
                                  phase_codes[$urandom_range(1, 2)]);
                    end
                end
            end
            else if (pick < 70)
            begin
                load_row(8'($urandom_range(255)), 5'($urandom_range(31)),
                         16'($urandom_range(16'hFFFF)));
            end
            else if (pick < 80)
            begin
                send_item(CMD_UNUSED, 9'($urandom_range(511)), 9'($urandom_range(511)),
                          8'($urandom_range(255)), 5'($urandom_range(31)),
                          16'($urandom_range(16'hFFFF)));
            end
            else if (pick < 96)
            begin
                draw_char(8'($urandom_range(255)));
            end
            else
            begin
                settle();
            end
        end
    endtask

    initial
    begin
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 32;
        recv_stall_pct = 50;

        // Directed part: 16-pixel cells three rows high on a 40 x 20 screen,
        // so wraps and the bottom edge come after a few characters. A glyph
        // width of 20 saturates to 16.
        write_register(CFG_SCREEN_WIDTH, 9'd40);
        write_register(CFG_SCREEN_HEIGHT, 9'd20);
        write_register(CFG_GLYPH_WIDTH, 9'd20);
        write_register(CFG_GLYPH_HEIGHT, 9'd3);
        load_row(SPACE_CODE, 5'd0, 16'hFFFF);
        load_row(SPACE_CODE, 5'd1, 16'h0000);
        load_row(SPACE_CODE, 5'd2, 16'hA5A5);
        load_row(LAST_PRINTABLE, 5'd0, 16'h8000);
        load_row(LAST_PRINTABLE, 5'd1, 16'h0001);
        load_row(LAST_PRINTABLE, 5'd2, 16'h7FFE);
        // Loads of codes outside the printable range leave the store alone.
        load_row(SPACE_CODE - 8'd1, 5'd31, 16'hFFFF);
        load_row(LAST_PRINTABLE + 8'd1, 5'd0, 16'hFFFF);
        load_row(8'hFF, 5'd17, 16'h5555);
        send_item(CMD_UNUSED, 9'h1FF, 9'h1FF, 8'hFF, 5'd31, 16'hFFFF);
        place_cursor(9'd0, 9'd0);
        draw_char(LAST_PRINTABLE);
        draw_char(SPACE_CODE);
        // This one wraps to the second line and is drawn there.
        draw_char(LAST_PRINTABLE);
        draw_char(SPACE_CODE - 8'd1);
        draw_char(LAST_PRINTABLE + 8'd1);
        draw_char(8'hFF);
        draw_char(LAST_PRINTABLE);
        // A space that wraps is swallowed without any transfer.
        draw_char(SPACE_CODE);
        // Far below the screen but with no wrap, the character is still drawn.
        place_cursor(9'd0, 9'd500);
        draw_char(LAST_PRINTABLE);
        // From the far corner the wrap runs past the bottom: output stops
        // until the next start.
        place_cursor(9'h1FF, 9'h1FF);
        draw_char(LAST_PRINTABLE);
        draw_char(LAST_PRINTABLE);

        // Random part, one register setting per phase. The sender idles more
        // than the receiver halfway through, and the last phases run flat out.
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
            begin
                send_gap_pct = 50;
                recv_stall_pct = 32;
            end
            else if (phase == 4)
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            settle();
            configure_phase(phase);
            run_phase(18);
        end
        settle();

        if (board.fault_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
